// ===== rtl/core/sfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants of the serial command framer queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int CMD_LEN     = 16;
  localparam int QUEUE_DEPTH = 8;

  // one staging slot beyond the queued ones
  localparam int SLOTS  = QUEUE_DEPTH + 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = (CMD_LEN > 2) ? $clog2(CMD_LEN) : 1;
  localparam int LEN_W  = IDX_W;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PW    = $clog2(OPQ_DEPTH);
  localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1) + 1;

  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  typedef enum logic [1:0] {
    OP_ID,
    OP_CHAR,
    OP_END,
    OP_TAKE
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
  } op_t;

  typedef struct packed {
    logic       queue_empty;
    logic [7:0] cmd_id;
    logic [7:0] param_char;
    logic       char_valid;
    logic       last;
  } res_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/sfq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_front
// Accepts items, tracks command framing and turns each item into an operation.
// ----------------------------------------------------------------------------
module sfq_front
  import sfq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_full,
  output logic            op_wr_en,
  output op_t             op_wr,
  input  wire logic       op_full
);

  logic             in_param_r, in_param_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic             accept;

  assign in_full = op_full;
  assign accept  = in_push && !op_full;

  always_comb begin
    in_param_nxt = in_param_r;
    count_nxt    = count_r;
    tlen_nxt     = tlen_r;
    op_wr_en     = 1'b0;
    op_wr.kind   = OP_TAKE;
    op_wr.data   = in_rx_byte;
    op_wr.idx    = count_r;
    op_wr.len    = tlen_r;
    if (accept) begin
      priority if (in_func) begin
        op_wr_en   = 1'b1;
        op_wr.kind = OP_TAKE;
      end else if (in_rx_byte == BYTE_CR) begin
        op_wr_en = 1'b0;
      end else if (!in_param_r) begin
        op_wr_en     = 1'b1;
        op_wr.kind   = OP_ID;
        in_param_nxt = 1'b1;
        count_nxt    = '0;
        tlen_nxt     = '0;
      end else if (in_rx_byte != BYTE_LF && count_r < IDX_W'(CMD_LEN - 1)) begin
        op_wr_en   = 1'b1;
        op_wr.kind = OP_CHAR;
        if (tlen_r == count_r && in_rx_byte != BYTE_NUL) begin
          tlen_nxt = tlen_r + 1'b1;
        end
        count_nxt = count_r + 1'b1;
      end else begin
        op_wr_en     = 1'b1;
        op_wr.kind   = OP_END;
        in_param_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_param_r <= 1'b0;
      count_r    <= '0;
      tlen_r     <= '0;
    end else begin
      in_param_r <= in_param_nxt;
      count_r    <= count_nxt;
      tlen_r     <= tlen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sfq_op_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_op_queue
// Short queue of operations between the front and the back.
// ----------------------------------------------------------------------------
module sfq_op_queue
  import sfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire op_t  wr_op,
  output logic      full,
  input  wire logic rd_en,
  output op_t       rd_op,
  output logic      empty
);

  op_t               slot_r [OPQ_DEPTH];
  logic [OPQ_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OPQ_CW-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign full  = (cnt_r == OPQ_CW'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_op = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + OPQ_CW'(do_wr) - OPQ_CW'(do_rd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sfq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_back
// Executes operations: stores commands, pops them and emits result items.
// ----------------------------------------------------------------------------
module sfq_back
  import sfq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire op_t   op_rd,
  input  wire logic  op_empty,
  output logic       op_rd_en,
  output logic       out_empty,
  input  wire logic  out_pop,
  output res_t       out_res
);

  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [7:0]        ids_r  [SLOTS];
  logic [LEN_W-1:0]  lens_r [SLOTS];
  logic [7:0]        mem    [SLOTS][CMD_LEN];
  logic [SLOT_W-1:0] em_slot_r;
  logic [7:0]        em_id_r;
  logic [LEN_W-1:0]  em_len_r;
  logic [IDX_W-1:0]  em_idx_r;
  logic              pend_r;
  logic [7:0]        pend_id_r;
  logic              pend_last_r;
  logic [7:0]        rd_data_r;
  res_t              rq_r [RQ_DEPTH];
  logic [RQ_PW-1:0]  rq_wr_r, rq_rd_r;
  logic [RQ_CW-1:0]  rq_cnt_r;

  logic              room, op_go, issue, em_last;
  logic              push_ok, pop_entry, start_emit;
  logic              rq_push, rq_pop;
  res_t              rq_in;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign room    = (rq_cnt_r + RQ_CW'(pend_r)) < RQ_CW'(RQ_DEPTH);
  assign em_last = (em_idx_r == IDX_W'(em_len_r - 1'b1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start_emit) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (issue && em_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    op_go      = (state_r == BK_IDLE) && !op_empty && !pend_r && room;
    op_rd_en   = op_go;
    issue      = (state_r == BK_EMIT) && room;
    push_ok    = op_go && (op_rd.kind == OP_END) && (count_r < CNT_W'(QUEUE_DEPTH));
    pop_entry  = op_go && (op_rd.kind == OP_TAKE) && (count_r != '0);
    start_emit = pop_entry && (lens_r[head_r] != '0);
    rq_push    = 1'b0;
    rq_in      = '0;
    if (pend_r) begin
      rq_push          = 1'b1;
      rq_in.cmd_id     = pend_id_r;
      rq_in.param_char = rd_data_r;
      rq_in.char_valid = 1'b1;
      rq_in.last       = pend_last_r;
    end else if (op_go && op_rd.kind == OP_TAKE) begin
      if (count_r == '0) begin
        rq_push           = 1'b1;
        rq_in.queue_empty = 1'b1;
        rq_in.last        = 1'b1;
      end else if (!start_emit) begin
        rq_push      = 1'b1;
        rq_in.cmd_id = ids_r[head_r];
        rq_in.last   = 1'b1;
      end
    end
  end

  // command store
  always_ff @(posedge clk) begin
    if (op_go && op_rd.kind == OP_CHAR) begin
      mem[tail_r][op_rd.idx] <= op_rd.data;
    end
    if (issue) begin
      rd_data_r <= mem[em_slot_r][em_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (op_go && op_rd.kind == OP_ID) begin
      ids_r[tail_r] <= op_rd.data;
    end
    if (push_ok) begin
      lens_r[tail_r] <= op_rd.len;
    end
    if (start_emit) begin
      em_slot_r <= head_r;
      em_id_r   <= ids_r[head_r];
      em_len_r  <= lens_r[head_r];
    end
    if (issue) begin
      pend_id_r   <= em_id_r;
      pend_last_r <= em_last;
    end
    if (rq_push) begin
      rq_r[rq_wr_r] <= rq_in;
    end
  end

  assign rq_pop    = out_pop && (rq_cnt_r != '0);
  assign out_empty = (rq_cnt_r == '0);
  assign out_res   = rq_r[rq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      em_idx_r <= '0;
      pend_r   <= 1'b0;
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (push_ok) begin
        tail_r <= slot_inc(tail_r);
      end
      if (pop_entry) begin
        head_r <= slot_inc(head_r);
      end
      count_r <= count_r + CNT_W'(push_ok) - CNT_W'(pop_entry);
      if (start_emit) begin
        em_idx_r <= '0;
      end else if (issue) begin
        em_idx_r <= em_idx_r + 1'b1;
      end
      if (rq_push) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      rq_cnt_r <= rq_cnt_r + RQ_CW'(rq_push) - RQ_CW'(rq_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("command count beyond queue depth");

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_pend_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == BK_EMIT))
    else $error("memory read outside emit");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (em_idx_r < em_len_r))
    else $error("emit index past stored length");

  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (tail_r == head_r))
    else $error("tail and head differ on empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/serial_command_framer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_framer_queue
// Frames serial bytes into commands, queues them and emits them on request.
//
// Input channel: push/full with in_func and in_rx_byte. A byte item (func 0)
// is framed: carriage returns skipped, first byte is the ID, then parameter
// bytes up to newline or CMD_LEN-1 bytes. A take item (func 1) pops the
// oldest command. Result channel: empty/pop, one item per parameter byte
// before the first zero byte, or a single item for an empty parameter or
// an empty queue; last marks the final item of each take.
// Throughput: one input item per cycle while the operation queue has room.
// A take reads the command memory once per parameter byte; full rises when
// the two-entry operation queue fills. With the back end idle, a result for
// an empty queue or an empty parameter enters the result queue as the take
// is read; a parameter byte first passes the emit state and the memory read
// register. Reset clears framing state and the operation, command and result
// queues; no clearing pass. A stalled receiver fills the four-entry result
// queue, which stops the back end, then the operation queue, then raises full.
// ----------------------------------------------------------------------------
module serial_command_framer_queue
  import sfq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_queue_empty,
  output logic [7:0]      out_cmd_id,
  output logic [7:0]      out_param_char,
  output logic            out_char_valid,
  output logic            out_last
);

  op_t  op_wr, op_rd;
  logic op_wr_en, op_full, op_rd_en, op_empty;
  res_t res;

  sfq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .op_wr_en   (op_wr_en),
    .op_wr      (op_wr),
    .op_full    (op_full)
  );

  sfq_op_queue u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (op_wr_en),
    .wr_op (op_wr),
    .full  (op_full),
    .rd_en (op_rd_en),
    .rd_op (op_rd),
    .empty (op_empty)
  );

  sfq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_rd     (op_rd),
    .op_empty  (op_empty),
    .op_rd_en  (op_rd_en),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_queue_empty = res.queue_empty;
  assign out_cmd_id      = res.cmd_id;
  assign out_param_char  = res.param_char;
  assign out_char_valid  = res.char_valid;
  assign out_last        = res.last;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks serial_command_framer_queue against a cycle-free predictor of the
// command framer and its queue. A directed opening covers an empty-queue take,
// skipped carriage returns, zero and newline IDs, a zero inside a parameter
// and a full-length parameter. Random commands with random content, noise
// bytes and bursts of takes follow, with flood stretches that overrun the
// queue. Every result item is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import sfq_pkg::*;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TAKE    = 1'b1;
  localparam int   TOTAL_ITEMS  = 400;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   PRINT_CAP    = 100;

  class command_scoreboard;
    bit          in_cmd;
    int unsigned param_cnt;
    int unsigned text_len;
    logic [7:0]  cur_id;
    logic [7:0]  param_buf[CMD_LEN];
    logic [7:0]  slot_id[QUEUE_DEPTH];
    logic [7:0]  slot_param[QUEUE_DEPTH][CMD_LEN];
    int unsigned slot_len[QUEUE_DEPTH];
    int unsigned head;
    int unsigned count;
    res_t        expected_chars[$];
    int          errors;
    int          checked;
    int          takes;
    int          dropped;

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_input(bit take, logic [7:0] b);
      res_t        r;
      int unsigned slot;
      int unsigned len;
      if (take) begin
        takes++;
        if (count == 0) begin
          r = '{1'b1, 8'h00, 8'h00, 1'b0, 1'b1};
          expected_chars.push_back(r);
        end else begin
          slot  = head;
          len   = slot_len[slot];
          head  = (head + 1) % QUEUE_DEPTH;
          count = count - 1;
          if (len == 0) begin
            r = '{1'b0, slot_id[slot], 8'h00, 1'b0, 1'b1};
            expected_chars.push_back(r);
          end else begin
            for (int unsigned i = 0; i < len; i++) begin
              r = '{1'b0, slot_id[slot], slot_param[slot][i], 1'b1, (i + 1 == len)};
              expected_chars.push_back(r);
            end
          end
        end
      end else if (b != BYTE_CR) begin
        if (!in_cmd) begin
          cur_id    = b;
          param_cnt = 0;
          text_len  = 0;
          in_cmd    = 1'b1;
        end else if (b != BYTE_LF && param_cnt < CMD_LEN - 1) begin
          param_buf[param_cnt] = b;
          if (text_len == param_cnt && b != BYTE_NUL) text_len++;
          param_cnt++;
        end else begin
          in_cmd = 1'b0;
          if (count < QUEUE_DEPTH) begin
            slot          = (head + count) % QUEUE_DEPTH;
            slot_id[slot] = cur_id;
            for (int unsigned i = 0; i < text_len; i++) slot_param[slot][i] = param_buf[i];
            slot_len[slot] = text_len;
            count          = count + 1;
          end else begin
            dropped++;
          end
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("%0d ns: mismatch: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("result with nothing expected (id %h char %h last %b)",
                         got.cmd_id, got.param_char, got.last));
        return;
      end
      want = expected_chars.pop_front();
      checked++;
      if (got.queue_empty !== want.queue_empty)
        report($sformatf("queue_empty %b, want %b", got.queue_empty, want.queue_empty));
      if (got.cmd_id !== want.cmd_id)
        report($sformatf("cmd_id %h, want %h", got.cmd_id, want.cmd_id));
      if (got.param_char !== want.param_char)
        report($sformatf("param_char %h, want %h", got.param_char, want.param_char));
      if (got.char_valid !== want.char_valid)
        report($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_push    = 1'b0;
  logic       in_func    = FUNC_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_pop    = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic       out_queue_empty;
  logic [7:0] out_cmd_id;
  logic [7:0] out_param_char;
  logic       out_char_valid;
  logic       out_last;

  command_scoreboard board;
  res_t              seen;
  int                items_sent    = 0;
  int                stall_cycles  = 0;
  int                send_idle_pct = 11;
  int                recv_idle_pct = 72;

  serial_command_framer_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_rx_byte      (in_rx_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_queue_empty (out_queue_empty),
    .out_cmd_id      (out_cmd_id),
    .out_param_char  (out_param_char),
    .out_char_valid  (out_char_valid),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen = '{out_queue_empty, out_cmd_id, out_param_char, out_char_valid, out_last};
      board.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge; returns at a falling edge with the item taken
  task automatic send_item(input logic func, input logic [7:0] b);
    if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_sent >= TOTAL_ITEMS / 3) begin
      send_idle_pct = 72;
      recv_idle_pct = 11;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push    <= 1'b1;
    in_func    <= func;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    board.note_input(func == FUNC_TAKE, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_take();
    send_item(FUNC_TAKE, 8'($urandom));
  endtask

  task automatic send_command();
    int         n;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) send_item(FUNC_BYTE, BYTE_CR);
    send_item(FUNC_BYTE, 8'($urandom));
    n = ($urandom_range(0, 4) == 0) ? CMD_LEN - 1 : $urandom_range(0, CMD_LEN - 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        b = BYTE_NUL;
      end else begin
        do b = 8'($urandom); while (b == BYTE_CR || b == BYTE_LF);
      end
      send_item(FUNC_BYTE, b);
      if ($urandom_range(0, 19) == 0) send_item(FUNC_BYTE, BYTE_CR);
      if ($urandom_range(0, 29) == 0) send_take();
    end
    if (n == CMD_LEN - 1) begin
      do b = 8'($urandom); while (b == BYTE_CR);
      send_item(FUNC_BYTE, b);
    end else begin
      send_item(FUNC_BYTE, BYTE_LF);
    end
  endtask

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int  r;
    int  take_pct;
    bit  flood;
    board = new;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(FUNC_TAKE, 8'hFF);
    send_item(FUNC_BYTE, BYTE_CR);
    send_item(FUNC_BYTE, BYTE_NUL);
    send_item(FUNC_BYTE, BYTE_LF);
    send_item(FUNC_BYTE, BYTE_LF);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, BYTE_NUL);
    send_item(FUNC_BYTE, 8'h55);
    send_item(FUNC_BYTE, BYTE_LF);
    send_item(FUNC_BYTE, 8'h80);
    for (int i = 0; i < CMD_LEN - 1; i++) begin
      send_item(FUNC_BYTE, i[0] ? 8'(8'h7F - i) : 8'(8'h80 + i));
    end
    send_item(FUNC_BYTE, 8'h41);
    repeat (3) send_take();

    flood = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 11) == 0) flood = !flood;
      take_pct = flood ? 8 : 40;
      r = $urandom_range(0, 99);
      if (r < take_pct) begin
        repeat ($urandom_range(1, 3)) send_take();
      end else if (r < take_pct + 10) begin
        repeat ($urandom_range(1, 3)) send_item(FUNC_BYTE, 8'($urandom));
      end else begin
        send_command();
      end
    end
    in_push <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, %0d of them takes; checked %0d result items.",
             items_sent, board.takes, board.checked);
    $display("Commands lost to a full queue: %0d; mismatches: %0d.",
             board.dropped, board.errors);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
